// File: rtl/core/lsd_radix_sort_decimal_defines.svh
// assertion macros used by the port-level checker
`ifndef LSD_RADIX_SORT_DECIMAL_DEFINES_SVH
`define LSD_RADIX_SORT_DECIMAL_DEFINES_SVH

// clocked property, disabled while reset is low
`define LSD_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("lsd assertion failed");

// same with a caller message
`define LSD_ASSERT_MSG(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

`endif

// File: rtl/core/lsd_pkg.sv
// constants shared by the decimal radix sorter and its checker
`default_nettype none

package lsd_pkg;
  localparam int MAX_COUNT = 64;
  localparam int RADIX     = 10;
  localparam int VAL_W     = 31;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = $clog2(MAX_COUNT);
  localparam int CNT_W     = $clog2(MAX_COUNT + 1);
  localparam int DIGIT_W   = $clog2(RADIX);
  localparam int MEM_W     = 2 * VAL_W;
  // q / 10 == (q * DIV10_MAGIC) >> DIV10_SHIFT for any q below 2**32
  localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;
  localparam int DIV10_SHIFT = 35;
  localparam int PROD_W      = VAL_W + 32;
  localparam int QDIV_W      = PROD_W - DIV10_SHIFT;
endpackage

`default_nettype wire

// File: rtl/core/lsd_radix_sort_decimal.sv
// decimal lsd radix sorter: load, bucket passes in ping-pong memories, ordered output
//
//  channel  | dir | tdata                  | tlast     | tuser
//  s_axis   | in  | [30:0] value           | last      | -
//  m_axis   | out | [30:0] sorted_value    | last_out  | [0] dropped
//
// loading takes one word per cycle; the sort starts on the word marked last.
// each digit pass streams the stored words twice through one memory read port
// (count, scatter), with a prefix sum over the ten buckets between the two.
// passes = decimal digits of the largest stored value (1 to 10); the output side
// reads one word at a time, issuing the next read only once the last has arrived.
// rst_ni clears control state only; memory contents stay undefined until written.
// input is not taken while sorting or emitting; output stalls hold the current word.
`default_nettype none

module lsd_radix_sort_decimal (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [lsd_pkg::DATA_W-1:0]  s_axis_tdata,   // [30:0] value, [31] zero
  input  logic                        s_axis_tlast,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [lsd_pkg::DATA_W-1:0]  m_axis_tdata,   // [30:0] sorted_value, [31] zero
  output logic                        m_axis_tlast,
  output logic [0:0]                  m_axis_tuser    // [0] dropped
);
  import lsd_pkg::*;

  typedef enum logic [2:0] {
    ST_LOAD, ST_COUNT, ST_PREFIX, ST_SCATTER, ST_OUTPUT
  } state_e;

  state_e              state_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                ovf_q;
  logic                sel_q;      // memory holding the current order
  logic                nz_q;       // some quotient left after this pass
  logic [CNT_W-1:0]    rd_ptr_q;
  logic                s1_v_q;
  logic                s2_v_q;
  logic [VAL_W-1:0]    s2_val_q;
  logic [VAL_W-1:0]    s2_q_q;
  logic [QDIV_W-1:0]   s2_qdiv_q;
  logic [CNT_W-1:0]    bkt_q [RADIX];
  logic [DIGIT_W-1:0]  pidx_q;
  logic [CNT_W-1:0]    sum_q;
  logic [CNT_W-1:0]    out_ptr_q;
  logic                inflight_q;
  logic                ovalid_q;
  logic [VAL_W-1:0]    odata_q;
  logic                olast_q;

  // the two element memories, word = {quotient, value}
  logic [MEM_W-1:0]    mem0 [MAX_COUNT];
  logic [MEM_W-1:0]    mem1 [MAX_COUNT];
  logic [MEM_W-1:0]    rd0_q, rd1_q, rdata;
  logic                we0, we1;
  logic [ADDR_W-1:0]   waddr, raddr;
  logic [MEM_W-1:0]    wdata;

  logic                in_acc, load_wr, store_ok;
  logic                issue, pipe_end, out_issue, out_take;
  logic [DIGIT_W-1:0]  digit;
  logic [PROD_W-1:0]   prod;
  logic [VAL_W-1:0]    rd_val, rd_q;

  // input handshake
  assign s_axis_tready = (state_q == ST_LOAD);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign store_ok      = (cnt_q < CNT_W'(MAX_COUNT));
  assign load_wr       = in_acc && store_ok;

  // element stream through the count and scatter pipeline
  assign issue    = ((state_q == ST_COUNT) || (state_q == ST_SCATTER)) && (rd_ptr_q < cnt_q);
  assign pipe_end = (rd_ptr_q == cnt_q) && !s1_v_q && !s2_v_q;

  // output stream: one read in flight, output register free on arrival
  assign out_take  = ovalid_q && m_axis_tready;
  assign out_issue = (state_q == ST_OUTPUT) && !inflight_q && (out_ptr_q < cnt_q)
                     && (!ovalid_q || m_axis_tready);

  // source memory read data
  assign rdata  = sel_q ? rd1_q : rd0_q;
  assign rd_val = rdata[VAL_W-1:0];
  assign rd_q   = rdata[MEM_W-1:VAL_W];
  assign prod   = PROD_W'(rd_q) * PROD_W'(DIV10_MAGIC);

  // decimal digit = q - 10 * (q / 10), only the low four bits matter
  assign digit = s2_q_q[DIGIT_W-1:0]
                 - {s2_qdiv_q[0], 3'b000}
                 - {s2_qdiv_q[2:0], 1'b0};

  // memory port control
  always_comb begin
    raddr = (state_q == ST_OUTPUT) ? out_ptr_q[ADDR_W-1:0] : rd_ptr_q[ADDR_W-1:0];
    if (state_q == ST_SCATTER) begin
      waddr = bkt_q[digit][ADDR_W-1:0];
      wdata = {VAL_W'(s2_qdiv_q), s2_val_q};
      we0   = s2_v_q && sel_q;
      we1   = s2_v_q && !sel_q;
    end else begin
      waddr = cnt_q[ADDR_W-1:0];
      wdata = {s_axis_tdata[VAL_W-1:0], s_axis_tdata[VAL_W-1:0]};
      we0   = load_wr && !sel_q;
      we1   = load_wr && sel_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we0) begin
      mem0[waddr] <= wdata;
    end
    rd0_q <= mem0[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (we1) begin
      mem1[waddr] <= wdata;
    end
    rd1_q <= mem1[raddr];
  end

  // payload stages of the digit pipeline
  always_ff @(posedge clk_i) begin
    s2_val_q  <= rd_val;
    s2_q_q    <= rd_q;
    s2_qdiv_q <= prod[PROD_W-1:DIV10_SHIFT];
  end

  // sequencer, bucket counters and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      cnt_q      <= '0;
      ovf_q      <= 1'b0;
      sel_q      <= 1'b0;
      nz_q       <= 1'b0;
      rd_ptr_q   <= '0;
      s1_v_q     <= 1'b0;
      s2_v_q     <= 1'b0;
      pidx_q     <= '0;
      sum_q      <= '0;
      out_ptr_q  <= '0;
      inflight_q <= 1'b0;
      ovalid_q   <= 1'b0;
      odata_q    <= '0;
      olast_q    <= 1'b0;
      for (int k = 0; k < RADIX; k++) begin
        bkt_q[k] <= '0;
      end
    end else begin
      s1_v_q <= issue;
      s2_v_q <= s1_v_q;
      if (issue) begin
        rd_ptr_q <= CNT_W'(rd_ptr_q + 1'b1);
      end
      unique case (state_q)
        ST_LOAD: begin
          if (in_acc) begin
            if (store_ok) begin
              cnt_q <= CNT_W'(cnt_q + 1'b1);
            end else begin
              ovf_q <= 1'b1;
            end
            if (s_axis_tlast) begin
              state_q  <= ST_COUNT;
              rd_ptr_q <= '0;
              nz_q     <= 1'b0;
              for (int k = 0; k < RADIX; k++) begin
                bkt_q[k] <= '0;
              end
            end
          end
        end
        ST_COUNT: begin
          if (s2_v_q) begin
            bkt_q[digit] <= CNT_W'(bkt_q[digit] + 1'b1);
          end
          if (pipe_end) begin
            state_q <= ST_PREFIX;
            pidx_q  <= '0;
            sum_q   <= '0;
          end
        end
        ST_PREFIX: begin
          // counts become starting offsets, one bucket a cycle
          bkt_q[pidx_q] <= sum_q;
          sum_q         <= CNT_W'(sum_q + bkt_q[pidx_q]);
          if (pidx_q == DIGIT_W'(RADIX - 1)) begin
            state_q  <= ST_SCATTER;
            rd_ptr_q <= '0;
          end else begin
            pidx_q <= DIGIT_W'(pidx_q + 1'b1);
          end
        end
        ST_SCATTER: begin
          if (s2_v_q) begin
            bkt_q[digit] <= CNT_W'(bkt_q[digit] + 1'b1);
            if (s2_qdiv_q != '0) begin
              nz_q <= 1'b1;
            end
          end
          if (pipe_end) begin
            sel_q    <= !sel_q;
            rd_ptr_q <= '0;
            if (nz_q) begin
              state_q <= ST_COUNT;
              nz_q    <= 1'b0;
              for (int k = 0; k < RADIX; k++) begin
                bkt_q[k] <= '0;
              end
            end else begin
              state_q   <= ST_OUTPUT;
              out_ptr_q <= '0;
            end
          end
        end
        ST_OUTPUT: begin
          if (out_issue) begin
            inflight_q <= 1'b1;
            out_ptr_q  <= CNT_W'(out_ptr_q + 1'b1);
          end else begin
            inflight_q <= 1'b0;
          end
          if (inflight_q) begin
            ovalid_q <= 1'b1;
            odata_q  <= rd_val;
            olast_q  <= (out_ptr_q == cnt_q);
          end else if (out_take) begin
            ovalid_q <= 1'b0;
            if (olast_q) begin
              state_q <= ST_LOAD;
              cnt_q   <= '0;
              ovf_q   <= 1'b0;
              olast_q <= 1'b0;
            end
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

  // output ports
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = DATA_W'(odata_q);
  assign m_axis_tlast  = olast_q;
  assign m_axis_tuser  = ovf_q;

endmodule

`default_nettype wire

// File: rtl/core/lsd_chk.sv
// port-level checker for the decimal radix sorter, bound to the top level
`default_nettype none
`include "lsd_radix_sort_decimal_defines.svh"

module lsd_chk (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        s_axis_tvalid,
  input wire logic                        s_axis_tready,
  input wire logic                        s_axis_tlast,
  input wire logic                        m_axis_tvalid,
  input wire logic                        m_axis_tready,
  input wire logic [lsd_pkg::DATA_W-1:0]  m_axis_tdata,
  input wire logic                        m_axis_tlast,
  input wire logic [0:0]                  m_axis_tuser
);
  import lsd_pkg::*;

  logic in_last_acc, out_acc, out_last_acc;

  assign in_last_acc  = s_axis_tvalid && s_axis_tready && s_axis_tlast;
  assign out_acc      = m_axis_tvalid && m_axis_tready;
  assign out_last_acc = out_acc && m_axis_tlast;

  // no result while the store is still taking words
  `LSD_ASSERT(a_no_out_while_load, clk_i, rst_ni, m_axis_tvalid |-> !s_axis_tready)
  // a set closed by last stops further input
  `LSD_ASSERT(a_close_stops_input, clk_i, rst_ni, in_last_acc |=> !s_axis_tready)
  // end of the run reopens the input
  `LSD_ASSERT_MSG(a_run_end_reopens, clk_i, rst_ni, out_last_acc |=> s_axis_tready,
                  "input not reopened after final word")
  // dropped flag is the same on every word of a run
  `LSD_ASSERT(a_flag_steady, clk_i, rst_ni,
              (out_acc && !m_axis_tlast) |=> $stable(m_axis_tuser))
  // a stalled word holds
  `LSD_ASSERT(a_stall_holds, clk_i, rst_ni,
              (m_axis_tvalid && !m_axis_tready) |=>
              (m_axis_tvalid && $stable(m_axis_tdata[VAL_W-1:0]) && $stable(m_axis_tlast)))

endmodule

bind lsd_radix_sort_decimal lsd_chk u_lsd_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// File: tb/tb_lsd_radix_sort_decimal.sv
// testbench for the decimal lsd radix sorter: stream stimulus, sorted-order prediction, checks
`default_nettype none

module tb_lsd_radix_sort_decimal;
  timeunit 1ns;
  timeprecision 1ps;

  import lsd_pkg::*;

  localparam int IDLE_PCT    = 20;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_WAIT  = 50;
  localparam int RANDOM_WORDS = 300;

  // one sorted output word as predicted
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             last;
    logic             dropped;
  } sorted_word_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata = '0;   // [30:0] value, [31] zero
  logic              s_axis_tlast = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [DATA_W-1:0] m_axis_tdata;        // [30:0] sorted_value, [31] zero
  logic              m_axis_tlast;
  logic [0:0]        m_axis_tuser;        // [0] dropped

  // predictor state: words held for the current run, and the drop flag
  logic [VAL_W-1:0] held_values[$];
  logic             held_dropped = 1'b0;
  sorted_word_t     pending_sorted[$];

  // words of the next run to send
  logic [VAL_W-1:0] run_values[$];

  sorted_word_t front_word;
  int  error_count = 0;
  int  stall_cycles = 0;
  int  words_sent = 0;
  bit  steady_flow = 1'b0;

  lsd_radix_sort_decimal uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 10 ns clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // receiver stalls about one cycle in five unless the flow is steady
  always @(negedge clk_i) begin
    m_axis_tready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
  end

  task automatic note_mismatch(input string what);
    error_count++;
    if (error_count <= 10) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // predictor: store or drop the word, and on last order the held set ascending
  task automatic predict_sorted(input logic [VAL_W-1:0] value, input logic last);
    logic [VAL_W-1:0] ordered[$];
    sorted_word_t     w;
    int               pos;
    if (held_values.size() < MAX_COUNT) held_values.push_back(value);
    else held_dropped = 1'b1;
    if (last) begin
      foreach (held_values[i]) begin
        pos = 0;
        while (pos < ordered.size() && ordered[pos] <= held_values[i]) pos++;
        ordered.insert(pos, held_values[i]);
      end
      foreach (ordered[i]) begin
        w.value   = ordered[i];
        w.last    = (i == ordered.size() - 1);
        w.dropped = held_dropped;
        pending_sorted.push_back(w);
      end
      held_values.delete();
      held_dropped = 1'b0;
    end
  endtask

  // send one word, with an occasional gap before it; returns after acceptance
  task automatic send_word(input logic [VAL_W-1:0] value, input logic last);
    @(negedge clk_i);
    if (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, value};
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_sorted(value, last);
    words_sent++;
  endtask

  // send run_values with last on the final word, then release the bus
  task automatic send_run();
    foreach (run_values[i]) send_word(run_values[i], i == run_values.size() - 1);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    s_axis_tlast  <= 1'b0;
    run_values.delete();
  endtask

  task automatic wait_for_drain();
    while (pending_sorted.size() != 0) @(posedge clk_i);
  endtask

  // random value: full width, few small duplicates, or a random digit count
  function automatic logic [VAL_W-1:0] pick_value();
    logic [31:0] raw;
    logic [63:0] span;
    logic [63:0] pick;
    int          mode;
    mode = $urandom_range(9);
    raw  = $urandom;
    if (mode < 2) return raw[VAL_W-1:0];
    if (mode < 4) return VAL_W'($urandom_range(15));
    span = 64'd1;
    repeat ($urandom_range(1, 10)) span = span * 10;
    pick = {$urandom, $urandom} % span;
    if (pick > 64'h7FFF_FFFF) pick = pick & 64'h7FFF_FFFF;
    return pick[VAL_W-1:0];
  endfunction

  task automatic fill_random_run(input int count);
    repeat (count) run_values.push_back(pick_value());
  endtask

  // single words, duplicates, values of one, two, three, nine and ten digits
  task automatic test_digit_extremes();
    run_values = '{31'd0};
    send_run();
    run_values = '{31'h7FFF_FFFF};
    send_run();
    run_values = '{31'd5, 31'd3, 31'd5, 31'd0, 31'd9};
    send_run();
    run_values = '{31'd1000000000, 31'd999999999, 31'd10, 31'd9, 31'd100,
                   31'd1, 31'h7FFF_FFFF, 31'd0};
    send_run();
    run_values = '{31'd321, 31'd123, 31'd213, 31'd312, 31'd132, 31'd231};
    send_run();
  endtask

  // exactly full, one over with last on the dropped word, several over
  task automatic test_store_full();
    fill_random_run(MAX_COUNT);
    send_run();
    fill_random_run(MAX_COUNT + 1);
    send_run();
    wait_for_drain();
    fill_random_run(MAX_COUNT + 6);
    send_run();
  endtask

  // long stretch with no gaps and no stalls
  task automatic test_steady_stream();
    steady_flow = 1'b1;
    repeat (4) begin
      fill_random_run($urandom_range(1, 20));
      send_run();
    end
    wait_for_drain();
    steady_flow = 1'b0;
  endtask

  // random run sizes, mostly small, sometimes waiting for the output to drain
  task automatic test_random_runs();
    int target;
    int pick;
    target = words_sent + RANDOM_WORDS;
    while (words_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 80) fill_random_run($urandom_range(1, 12));
      else if (pick < 95) fill_random_run($urandom_range(13, 40));
      else if (pick < 98) fill_random_run($urandom_range(41, MAX_COUNT));
      else fill_random_run($urandom_range(MAX_COUNT + 1, MAX_COUNT + 4));
      send_run();
      if ($urandom_range(3) == 0) wait_for_drain();
    end
  endtask

  // output check and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("lsd_radix_sort_decimal: mismatch");
        $finish;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_sorted.size() == 0) begin
          note_mismatch($sformatf("unexpected word data=%h last=%b dropped=%b",
                                  m_axis_tdata, m_axis_tlast, m_axis_tuser[0]));
        end else begin
          front_word = pending_sorted.pop_front();
          if (m_axis_tdata !== {1'b0, front_word.value} ||
              m_axis_tlast !== front_word.last ||
              m_axis_tuser[0] !== front_word.dropped)
            note_mismatch($sformatf(
              "expected data=%h last=%b dropped=%b, got data=%h last=%b dropped=%b",
              {1'b0, front_word.value}, front_word.last, front_word.dropped,
              m_axis_tdata, m_axis_tlast, m_axis_tuser[0]));
        end
      end
    end
  end

  // reset, tests, drain and verdict
  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_digit_extremes();
    test_store_full();
    test_steady_stream();
    test_random_runs();
    wait_for_drain();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (error_count == 0 && pending_sorted.size() == 0) begin
      $display("lsd_radix_sort_decimal: match");
    end else begin
      $display("lsd_radix_sort_decimal: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
